// ===== design/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg
// shared constants, types and helpers of the rgb median filter
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int MAX_LINE_LENGTH = 1024;
    localparam int MAX_LINE_COUNT  = 1024;
    localparam int MAX_RADIUS      = 3;
    localparam int WIN_SIDE        = 2 * MAX_RADIUS + 1;
    localparam int WIN_N           = WIN_SIDE * WIN_SIDE;
    localparam int RING            = 2 * MAX_RADIUS + 2;
    localparam int ROW_W           = $clog2(RING);
    localparam int POS_W           = 11;
    localparam int ADDR_W          = $clog2(MAX_LINE_LENGTH);
    localparam int CNT_W           = $clog2(WIN_N + 1);
    localparam int CH_W            = 8;
    localparam int PIX_W           = 3 * CH_W;
    localparam int CRED_W          = 3;

    // register indexes
    localparam logic [1:0] REG_LEN = 2'd0;
    localparam logic [1:0] REG_CNT = 2'd1;
    localparam logic [1:0] REG_RAD = 2'd2;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic                                     v;
        logic                                     last;
        logic [2:0][WIN_N-1:0][CH_W-1:0]          vals;
        logic [2:0][1:0][WIN_N-1:0]               alive;
        logic [2:0][1:0][CNT_W-1:0]               k;
        logic [2:0][1:0][CH_W-1:0]                res;
    } t_sel_bus;

    function automatic logic [CNT_W-1:0] popcount(input logic [WIN_N-1:0] m);
        logic [CNT_W-1:0] acc;
        acc = '0;
        for (int e = 0; e < WIN_N; e++) begin
            acc = acc + CNT_W'(m[e]);
        end
        return acc;
    endfunction

endpackage

// ===== design/rmf_ram.sv =====
// ----------------------------------------------------------------------------
// rmf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rmf_win_cell.sv =====
// ----------------------------------------------------------------------------
// rmf_win_cell
// one window column: a column of pixels with valid bits, shifted to the next
// ----------------------------------------------------------------------------
module rmf_win_cell (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_shift,
    input  logic                                      i_clr,
    input  rmf_pkg::t_pix [rmf_pkg::WIN_SIDE-1:0]     i_px,
    input  logic [rmf_pkg::WIN_SIDE-1:0]              i_pv,
    output rmf_pkg::t_pix [rmf_pkg::WIN_SIDE-1:0]     o_px,
    output logic [rmf_pkg::WIN_SIDE-1:0]              o_pv
);

    rmf_pkg::t_pix [rmf_pkg::WIN_SIDE-1:0] r_px;
    logic [rmf_pkg::WIN_SIDE-1:0]          r_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (i_shift) begin
            r_pv <= i_clr ? '0 : i_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_px <= i_px;
        end
    end

    assign o_px = r_px;
    assign o_pv = r_pv;

endmodule

// ===== design/rmf_sel_cell.sv =====
// ----------------------------------------------------------------------------
// rmf_sel_cell
// one bit step of a radix order-statistic select, msb first
// ----------------------------------------------------------------------------
module rmf_sel_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  rmf_pkg::t_sel_bus i_bus,
    output rmf_pkg::t_sel_bus o_bus
);

    rmf_pkg::t_sel_bus                        n_bus;
    rmf_pkg::t_sel_bus                        r_bus;
    logic                                     r_v;
    logic [2:0][rmf_pkg::WIN_N-1:0]           msb;
    logic [2:0][1:0][rmf_pkg::WIN_N-1:0]      zm;
    logic [2:0][1:0][rmf_pkg::CNT_W-1:0]      zc;

    always_comb begin
        n_bus = i_bus;
        for (int c = 0; c < 3; c++) begin
            for (int e = 0; e < rmf_pkg::WIN_N; e++) begin
                msb[c][e]         = i_bus.vals[c][e][rmf_pkg::CH_W-1];
                n_bus.vals[c][e]  = {i_bus.vals[c][e][rmf_pkg::CH_W-2:0], 1'b0};
            end
            for (int s = 0; s < 2; s++) begin
                zm[c][s] = i_bus.alive[c][s] & ~msb[c];
                zc[c][s] = rmf_pkg::popcount(zm[c][s]);
                // rank falls among the zeros: keep them, else skip past them
                if (i_bus.k[c][s] < zc[c][s]) begin
                    n_bus.alive[c][s] = zm[c][s];
                    n_bus.res[c][s]   = {i_bus.res[c][s][rmf_pkg::CH_W-2:0], 1'b0};
                end else begin
                    n_bus.alive[c][s] = i_bus.alive[c][s] & msb[c];
                    n_bus.k[c][s]     = i_bus.k[c][s] - zc[c][s];
                    n_bus.res[c][s]   = {i_bus.res[c][s][rmf_pkg::CH_W-2:0], 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_bus.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    always_comb begin
        o_bus   = r_bus;
        o_bus.v = r_v;
    end

endmodule

// ===== design/rgb_median_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_median_filter
// per-channel median over a clipped square window of an rgb frame
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/tready         tdata: red, green, blue
//                                                    tuser: operation
//  m_axis    out        m_axis_tvalid/tready         tdata: red, green, blue
//                                                    tlast: frame_end
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
//  mid-line one word is taken per cycle unless a waiting fetch holds s_axis;
//  around each line end the window chain fetches padding columns past the
//  line end and then preloads the start of the next line, one column per fetch.
//  a word that completes a window reaches the output through fetch, ram read,
//  window, count, 8 select cells and the output register.
//  reset is synchronous, active low; the line store needs no clearing pass.
//  a stall on m_axis freezes the whole chain; s_axis keeps taking words
//  while no fetch is waiting.
//
module rgb_median_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic [0:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int PW = rmf_pkg::POS_W;
    localparam int RW = rmf_pkg::ROW_W;
    localparam int WS = rmf_pkg::WIN_SIDE;

    // configuration registers
    logic [PW-1:0] r_len_reg, r_cnt_reg;
    logic [1:0]    r_rad_reg;
    logic [PW-1:0] len, cnt, rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_reg <= PW'(1024);
            r_cnt_reg <= PW'(1024);
            r_rad_reg <= 2'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rmf_pkg::REG_LEN: r_len_reg <= i_cfg_data;
                rmf_pkg::REG_CNT: r_cnt_reg <= i_cfg_data;
                rmf_pkg::REG_RAD: r_rad_reg <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // live extents, zero acts as one, large values saturate
    always_comb begin
        len = (r_len_reg == '0) ? PW'(1) :
              (r_len_reg > PW'(rmf_pkg::MAX_LINE_LENGTH)) ? PW'(rmf_pkg::MAX_LINE_LENGTH) :
              r_len_reg;
        cnt = (r_cnt_reg == '0) ? PW'(1) :
              (r_cnt_reg > PW'(rmf_pkg::MAX_LINE_COUNT)) ? PW'(rmf_pkg::MAX_LINE_COUNT) :
              r_cnt_reg;
        rad = (r_rad_reg == 2'd0) ? PW'(1) :
              (r_rad_reg > 2'(rmf_pkg::MAX_RADIUS)) ? PW'(rmf_pkg::MAX_RADIUS) :
              PW'(r_rad_reg);
    end

    // ------------------------------------------------------------------
    // input side: write position and the output schedule
    // ------------------------------------------------------------------
    logic [PW-1:0] r_in_pos, r_in_line, r_mo_pos, r_mo_line;
    logic [PW-1:0] n_in_pos, n_in_line, n_mo_pos, n_mo_line;
    logic [RW-1:0] r_in_row, n_in_row;
    logic          r_in_frame, n_in_frame;
    logic          sh_wr, sh_emit;
    logic [PW-1:0] sh_wpos, sh_r1, sh_c1;
    logic [RW-1:0] sh_wrow;
    logic          s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_pos   = r_in_pos;
        n_in_line  = r_in_line;
        n_in_row   = r_in_row;
        n_mo_pos   = r_mo_pos;
        n_mo_line  = r_mo_line;
        n_in_frame = r_in_frame;
        sh_emit    = 1'b0;
        // line bookkeeping against the live extents
        if (n_in_pos >= len) begin
            n_in_pos  = '0;
            n_in_line = n_in_line + PW'(1);
            n_in_row  = n_in_row + RW'(1);
        end
        if (n_in_line >= cnt) begin
            n_in_line = cnt;
            n_in_pos  = '0;
        end
        if (n_mo_pos >= len) begin
            n_mo_pos  = '0;
            n_mo_line = n_mo_line + PW'(1);
        end
        if (n_mo_line >= cnt) begin
            n_in_pos  = '0;
            n_in_line = '0;
            n_mo_pos  = '0;
            n_mo_line = '0;
        end
        // pixel store; surplus words past the last line are dropped
        sh_wr   = (s_axis_tuser[0] == rmf_pkg::OP_PIXEL) && (n_in_line < cnt);
        sh_wpos = n_in_pos;
        sh_wrow = n_in_row;
        if (sh_wr) begin
            n_in_pos = n_in_pos + PW'(1);
            if (n_in_pos >= len) begin
                n_in_pos  = '0;
                n_in_line = n_in_line + PW'(1);
                n_in_row  = n_in_row + RW'(1);
            end
        end
        // next output due once its clipped window has fully arrived
        sh_r1 = (n_mo_line + rad < cnt) ? n_mo_line + rad : cnt - PW'(1);
        sh_c1 = (n_mo_pos + rad < len) ? n_mo_pos + rad : len - PW'(1);
        sh_emit = (n_in_line > sh_r1) || ((n_in_line == sh_r1) && (n_in_pos > sh_c1));
        if (sh_emit) begin
            if ((n_mo_line == cnt - PW'(1)) && (n_mo_pos == len - PW'(1))) begin
                n_in_pos   = '0;
                n_in_line  = '0;
                n_mo_pos   = '0;
                n_mo_line  = '0;
                n_in_frame = !r_in_frame;
            end else begin
                n_mo_pos = n_mo_pos + PW'(1);
                if (n_mo_pos >= len) begin
                    n_mo_pos  = '0;
                    n_mo_line = n_mo_line + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos   <= '0;
            r_in_line  <= '0;
            r_in_row   <= '0;
            r_mo_pos   <= '0;
            r_mo_line  <= '0;
            r_in_frame <= 1'b0;
        end else if (s_acc) begin
            r_in_pos   <= n_in_pos;
            r_in_line  <= n_in_line;
            r_in_row   <= n_in_row;
            r_mo_pos   <= n_mo_pos;
            r_mo_line  <= n_mo_line;
            r_in_frame <= n_in_frame;
        end
    end

    // ------------------------------------------------------------------
    // column fetch: one column of the ring per cycle unless stalled, padding past line end
    // ------------------------------------------------------------------
    logic [PW-1:0]                 r_fx, r_fl, n_fx, n_fl, f_r1;
    logic [RW-1:0]                 r_frow, n_frow;
    logic                          r_fframe, n_fframe;
    logic [rmf_pkg::CRED_W-1:0]    r_credits;
    logic                          f_data, f_emit, f_ok, f_want, f_go, f_last, f_eol;
    logic                          en;

    assign en     = !m_axis_tvalid || m_axis_tready;
    assign f_data = r_fx < len;
    assign f_emit = r_fx >= rad;
    assign f_r1   = (r_fl + rad < cnt) ? r_fl + rad : cnt - PW'(1);
    assign f_ok   = !f_data || (r_fframe != r_in_frame) || (r_in_line > f_r1) ||
                    ((r_in_line == f_r1) && (r_in_pos > r_fx));
    assign f_want = f_ok && (!f_emit || (r_credits != '0));
    assign f_go   = f_want && en;
    assign f_last = f_emit && (r_fl == cnt - PW'(1)) && (r_fx - rad == len - PW'(1));
    assign f_eol  = r_fx >= len - PW'(1) + rad;

    // a word is taken while the fetch keeps pace with the writes
    assign s_axis_tready = !f_want ||
                           (f_go && f_emit && (r_credits == rmf_pkg::CRED_W'(1)) &&
                            (r_fx + PW'(1) < len));

    always_comb begin
        n_fx     = r_fx + PW'(1);
        n_fl     = r_fl;
        n_frow   = r_frow;
        n_fframe = r_fframe;
        if (f_last) begin
            n_fx     = '0;
            n_fl     = '0;
            n_frow   = r_frow + RW'(1);
            n_fframe = !r_fframe;
        end else if (f_eol) begin
            n_fx   = '0;
            n_fl   = r_fl + PW'(1);
            n_frow = r_frow + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx      <= '0;
            r_fl      <= '0;
            r_frow    <= '0;
            r_fframe  <= 1'b0;
            r_credits <= '0;
        end else begin
            if (f_go) begin
                r_fx     <= n_fx;
                r_fl     <= n_fl;
                r_frow   <= n_frow;
                r_fframe <= n_fframe;
            end
            r_credits <= r_credits + rmf_pkg::CRED_W'(s_acc && sh_emit)
                                   - rmf_pkg::CRED_W'(f_go && f_emit);
        end
    end

    // ------------------------------------------------------------------
    // line store ring, one ram per row slot
    // ------------------------------------------------------------------
    rmf_pkg::t_pix [rmf_pkg::RING-1:0] rd_data;
    rmf_pkg::t_pix                     wr_pix;

    assign wr_pix = {s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]};

    for (genvar s = 0; s < rmf_pkg::RING; s++) begin : g_ring
        rmf_ram #(
            .WIDTH (rmf_pkg::PIX_W),
            .DEPTH (rmf_pkg::MAX_LINE_LENGTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (s_acc && sh_wr && (sh_wrow == RW'(s))),
            .i_waddr (sh_wpos[rmf_pkg::ADDR_W-1:0]),
            .i_wdata (wr_pix),
            .i_re    (f_go),
            .i_raddr (r_fx[rmf_pkg::ADDR_W-1:0]),
            .o_rdata (rd_data[s])
        );
    end

    // fetch tags, aligned with the ram read data
    logic          r_a_v, r_a_emit, r_a_last;
    logic [PW-1:0] r_a_x, r_a_fl;
    logic [RW-1:0] r_a_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= f_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x    <= r_fx;
            r_a_fl   <= r_fl;
            r_a_row  <= r_frow;
            r_a_emit <= f_emit;
            r_a_last <= f_last;
        end
    end

    // ------------------------------------------------------------------
    // window: chain of column cells, newest column in cell 0
    // ------------------------------------------------------------------
    rmf_pkg::t_pix [WS-1:0] col_px;
    logic [WS-1:0]          col_pv;
    rmf_pkg::t_pix [WS-1:0] w_px [WS];
    logic [WS-1:0]          w_pv [WS];
    logic                   w_shift;

    always_comb begin
        for (int i = 0; i < WS; i++) begin
            col_px[i] = rd_data[RW'(r_a_row + RW'(i) - RW'(rmf_pkg::MAX_RADIUS))];
            // row inside the radius and inside the frame, column inside the line
            col_pv[i] = (r_a_x < len) &&
                        ((PW'(i) + rad >= PW'(rmf_pkg::MAX_RADIUS)) &&
                         (PW'(i) <= rad + PW'(rmf_pkg::MAX_RADIUS))) &&
                        ((r_a_fl + PW'(i) >= PW'(rmf_pkg::MAX_RADIUS)) &&
                         (r_a_fl + PW'(i) < cnt + PW'(rmf_pkg::MAX_RADIUS)));
        end
    end

    assign w_shift = en && r_a_v;

    for (genvar j = 0; j < WS; j++) begin : g_win
        if (j == 0) begin : g_head
            rmf_win_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_clr   (1'b0),
                .i_px    (col_px),
                .i_pv    (col_pv),
                .o_px    (w_px[j]),
                .o_pv    (w_pv[j])
            );
        end else begin : g_body
            // a new line starts with an empty window
            rmf_win_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_clr   (r_a_x == '0),
                .i_px    (w_px[j-1]),
                .i_pv    (w_pv[j-1]),
                .o_px    (w_px[j]),
                .o_pv    (w_pv[j])
            );
        end
    end

    logic r_c_v, r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_a_v && r_a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_last <= r_a_last;
        end
    end

    // ------------------------------------------------------------------
    // window flatten and count
    // ------------------------------------------------------------------
    logic [rmf_pkg::WIN_N-1:0]                       w_mask;
    logic [2:0][rmf_pkg::WIN_N-1:0][rmf_pkg::CH_W-1:0] w_vals;
    logic                                            r_p_v, r_p_last;
    logic [rmf_pkg::WIN_N-1:0]                       r_p_mask;
    logic [2:0][rmf_pkg::WIN_N-1:0][rmf_pkg::CH_W-1:0] r_p_vals;
    logic [rmf_pkg::CNT_W-1:0]                       r_p_n;

    always_comb begin
        for (int j = 0; j < WS; j++) begin
            for (int i = 0; i < WS; i++) begin
                w_mask[j*WS+i] = w_pv[j][i] && (PW'(j) <= {rad[PW-2:0], 1'b0});
                for (int c = 0; c < 3; c++) begin
                    w_vals[c][j*WS+i] = w_px[j][i][c*rmf_pkg::CH_W +: rmf_pkg::CH_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_last <= r_c_last;
            r_p_mask <= w_mask;
            r_p_vals <= w_vals;
            r_p_n    <= rmf_pkg::popcount(w_mask);
        end
    end

    // ------------------------------------------------------------------
    // select chain: two ranks per channel, one bit per cell
    // ------------------------------------------------------------------
    rmf_pkg::t_sel_bus sel_bus [rmf_pkg::CH_W+1];

    always_comb begin
        sel_bus[0].v    = r_p_v;
        sel_bus[0].last = r_p_last;
        sel_bus[0].vals = r_p_vals;
        for (int c = 0; c < 3; c++) begin
            // lower and upper middle rank, equal when the count is odd
            sel_bus[0].k[c][0]     = (r_p_n - rmf_pkg::CNT_W'(1)) >> 1;
            sel_bus[0].k[c][1]     = r_p_n >> 1;
            sel_bus[0].alive[c][0] = r_p_mask;
            sel_bus[0].alive[c][1] = r_p_mask;
            sel_bus[0].res[c][0]   = '0;
            sel_bus[0].res[c][1]   = '0;
        end
    end

    for (genvar b = 0; b < rmf_pkg::CH_W; b++) begin : g_sel
        rmf_sel_cell u_sel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (sel_bus[b]),
            .o_bus   (sel_bus[b+1])
        );
    end

    // ------------------------------------------------------------------
    // output register: floor mean of the two middle values
    // ------------------------------------------------------------------
    logic [2:0][rmf_pkg::CH_W:0] avg_sum;
    logic                        r_ov, r_olast;
    logic [23:0]                 r_odata;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            avg_sum[c] = {1'b0, sel_bus[rmf_pkg::CH_W].res[c][0]} +
                         {1'b0, sel_bus[rmf_pkg::CH_W].res[c][1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= sel_bus[rmf_pkg::CH_W].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_olast <= sel_bus[rmf_pkg::CH_W].last;
            r_odata <= {avg_sum[2][rmf_pkg::CH_W:1], avg_sum[1][rmf_pkg::CH_W:1],
                        avg_sum[0][rmf_pkg::CH_W:1]};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

// ===== design/rmf_checker.sv =====
// ----------------------------------------------------------------------------
// rmf_checker
// port level checks of the rgb median filter, bound to the top level
// ----------------------------------------------------------------------------
module rmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [10:0] i_cfg_data
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed under stall");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // configuration writes never wait
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind rgb_median_filter rmf_checker u_rmf_checker (.*);
